// ===== rtl/lss_pkg.sv =====
package lss_pkg;

   localparam int WordWidth = 32;
   localparam int PosWidth  = 5;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_SEARCH  = 2'd3
   } lss_op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } lss_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK
   } lss_state_type;

   typedef struct packed {
      lss_op_type                  op;
      logic signed [WordWidth-1:0] operand;
   } lss_cmd_type;

   typedef struct packed {
      logic        valid;
      lss_cmd_type cmd;
   } lss_head_type;

endpackage

// ===== rtl/lss_req_if.sv =====
interface lss_req_if import lss_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic signed [WordWidth-1:0] operand_value;

   modport source (output valid, output opcode, output operand_value, input ready);
   modport sink (input valid, input opcode, input operand_value, output ready);
endinterface

// ===== rtl/lss_rsp_if.sv =====
interface lss_rsp_if import lss_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic signed [WordWidth-1:0] result_value;
   logic [PosWidth-1:0]         position_from_top;
   logic                        last_of_run;

   modport source (output valid, output status, output result_value,
                   output position_from_top, output last_of_run, input ready);
   modport sink (input valid, input status, input result_value,
                 input position_from_top, input last_of_run, output ready);
endinterface

// ===== rtl/lss_ram.sv =====
module lss_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lss_front.sv =====
module lss_front import lss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lss_req_if.sink      req_chan,
   output lss_head_type head,
   input  logic         deq
);

   lss_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        enq;
   logic        take;

   assign req_chan.ready = (fill_ff != 2'd2);
   assign enq  = req_chan.valid && req_chan.ready;
   assign take = deq && (fill_ff != 2'd0);

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, enq} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // The opcode is decoded into an operation as the word enters the queue.
   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff].op      <= lss_op_type'(req_chan.opcode);
         entry_ff[wr_ptr_ff].operand <= req_chan.operand_value;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

// ===== rtl/lss_back.sv =====
module lss_back import lss_pkg::*; #(
   parameter int StackDepth = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  lss_head_type head,
   output logic         deq,
   lss_rsp_if.source    rsp_chan
);

   localparam int CntWidth  = $clog2(StackDepth + 1);
   localparam int AddrWidth = $clog2(StackDepth);

   lss_state_type               state_ff, state_in;
   logic [CntWidth-1:0]         count_ff, count_in;
   logic [AddrWidth-1:0]        addr_ff, addr_in;
   logic [CntWidth-1:0]         pos_ff, pos_in;
   lss_op_type                  op_ff, op_in;
   logic signed [WordWidth-1:0] key_ff, key_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   lss_status_type              status_ff, status_in;
   logic signed [WordWidth-1:0] value_ff, value_in;
   logic [PosWidth-1:0]         position_ff, position_in;
   logic                        last_ff, last_in;
   logic                        out_load;
   logic                        out_free;

   logic                        wr_en;
   logic signed [WordWidth-1:0] rd_data;
   logic                        is_empty;
   logic                        is_full;

   lss_ram #(
      .Width (WordWidth),
      .Depth (StackDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (head.cmd.operand),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CntWidth'(StackDepth));

   // The read address follows the next walk address every cycle, so the
   // registered read data always belongs to the address held in addr_ff.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      pos_in      = pos_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      deq         = 1'b0;
      wr_en       = 1'b0;
      out_load    = 1'b0;
      status_in   = STS_OK;
      value_in    = '0;
      position_in = '0;
      last_in     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               case (head.cmd.op)
                  OP_PUSH: begin
                     if (out_free) begin
                        deq      = 1'b1;
                        out_load = 1'b1;
                        if (is_full) begin
                           status_in = STS_OVERFLOW;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CntWidth'(1);
                           value_in = head.cmd.operand;
                        end
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        if (out_free) begin
                           deq       = 1'b1;
                           out_load  = 1'b1;
                           status_in = STS_EMPTY;
                        end
                     end else begin
                        deq      = 1'b1;
                        count_in = count_ff - CntWidth'(1);
                        addr_in  = AddrWidth'(count_ff - CntWidth'(1));
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        if (out_free) begin
                           deq       = 1'b1;
                           out_load  = 1'b1;
                           status_in = STS_EMPTY;
                        end
                     end else begin
                        deq      = 1'b1;
                        op_in    = head.cmd.op;
                        key_in   = head.cmd.operand;
                        addr_in  = AddrWidth'(count_ff - CntWidth'(1));
                        pos_in   = CntWidth'(1);
                        state_in = ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               out_load = 1'b1;
               value_in = rd_data;
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (op_ff == OP_DISPLAY) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  value_in    = rd_data;
                  position_in = PosWidth'(pos_ff);
                  last_in     = (addr_ff == '0);
                  if (addr_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     addr_in = addr_ff - AddrWidth'(1);
                     pos_in  = pos_ff + CntWidth'(1);
                  end
               end
            end else if (rd_data == key_ff) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  value_in    = key_ff;
                  position_in = PosWidth'(pos_ff);
                  state_in    = ST_IDLE;
               end
            end else if (addr_ff == '0) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  status_in = STS_NOT_FOUND;
                  value_in  = key_ff;
                  state_in  = ST_IDLE;
               end
            end else begin
               addr_in = addr_ff - AddrWidth'(1);
               pos_in  = pos_ff + CntWidth'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      pos_ff  <= pos_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      if (out_load) begin
         status_ff   <= status_in;
         value_ff    <= value_in;
         position_ff <= position_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.result_value      = value_ff;
   assign rsp_chan.position_from_top = position_ff;
   assign rsp_chan.last_of_run       = last_ff;

endmodule

// ===== rtl/lifo_stack_with_search_unit.sv =====
// Bounded last-in-first-out stack of signed 32-bit words with push, pop,
// display and search requests. Requests enter a two-word queue and are
// executed one at a time against a stack memory with one write port and
// one registered read port. A pop reads its word through that port before it
// answers. Display and search walk the memory from the top, one entry per cycle
// after a first registered read, a display only while the output register is
// free; display emits one word per entry and marks the final one with
// last_of_run. Every result waits in an output register, and the back end
// stalls only while that register is full and not taken.
module lifo_stack_with_search_unit import lss_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   lss_req_if.sink   req_chan,
   lss_rsp_if.source rsp_chan
);

   lss_head_type head;
   logic         deq;

   lss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .deq      (deq)
   );

   lss_back #(
      .StackDepth (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .deq      (deq),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/sv/tb_lifo_stack_with_search_unit.sv =====
module tb_lifo_stack_with_search_unit;
   import lss_pkg::*;

   localparam int StackDepth = 16;
   localparam int IdleLimit  = 3000;
   localparam int MaxReports = 40;

   typedef struct {
      lss_status_type              status;
      logic signed [WordWidth-1:0] value;
      logic [PosWidth-1:0]         position;
      logic                        last;
   } stack_word_type;

   logic clock = 1'b0;
   logic reset;

   lss_req_if req_chan ();
   lss_rsp_if rsp_chan ();

   lifo_stack_with_search_unit #(.STACK_DEPTH(StackDepth)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic signed [WordWidth-1:0] stack_mirror [StackDepth];
   int                          entries_held = 0;
   stack_word_type              pending_words [$];
   int                          mismatch_count = 0;
   bit                          gaps_on = 1'b0;
   int                          hold_off_len = 0;

   always #4 clock = ~clock;

   function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (mismatch_count < MaxReports) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
      mismatch_count++;
   endfunction

   // Mirrors the stack and queues every word that one request is to produce.
   function automatic void predict_stack_request(lss_op_type op,
                                                 logic signed [WordWidth-1:0] operand);
      stack_word_type w;
      int hit;
      w.status   = STS_OK;
      w.value    = '0;
      w.position = '0;
      w.last     = 1'b1;
      hit        = 0;
      case (op)
         OP_PUSH: begin
            if (entries_held >= StackDepth) begin
               w.status = STS_OVERFLOW;
            end else begin
               stack_mirror[entries_held] = operand;
               entries_held++;
               w.value = operand;
            end
            pending_words.push_back(w);
         end
         OP_POP: begin
            if (entries_held == 0) begin
               w.status = STS_EMPTY;
            end else begin
               entries_held--;
               w.value = stack_mirror[entries_held];
            end
            pending_words.push_back(w);
         end
         OP_DISPLAY: begin
            if (entries_held == 0) begin
               w.status = STS_EMPTY;
               pending_words.push_back(w);
            end else begin
               for (int i = 0; i < entries_held; i++) begin
                  w.value    = stack_mirror[entries_held - 1 - i];
                  w.position = PosWidth'(i + 1);
                  w.last     = (i + 1 == entries_held);
                  pending_words.push_back(w);
               end
            end
         end
         default: begin
            if (entries_held == 0) begin
               w.status = STS_EMPTY;
            end else begin
               for (int i = 0; i < entries_held; i++) begin
                  if (hit == 0 && stack_mirror[entries_held - 1 - i] == operand) begin
                     hit = i + 1;
                  end
               end
               w.value = operand;
               if (hit != 0) begin
                  w.position = PosWidth'(hit);
               end else begin
                  w.status = STS_NOT_FOUND;
               end
            end
            pending_words.push_back(w);
         end
      endcase
   endfunction

   function automatic logic signed [WordWidth-1:0] random_word();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return $urandom_range(0, 7) - 4;
         2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Keys are mostly taken from the stack so that searches hit at every depth.
   function automatic logic signed [WordWidth-1:0] pick_key();
      if (entries_held > 0 && $urandom_range(0, 2) != 0) begin
         return stack_mirror[$urandom_range(0, entries_held - 1)];
      end
      return random_word();
   endfunction

   function automatic lss_op_type weighted_op();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return OP_PUSH;
         4, 5:       return OP_POP;
         6:          return OP_DISPLAY;
         default:    return OP_SEARCH;
      endcase
   endfunction

   task automatic send_request(lss_op_type op, logic signed [WordWidth-1:0] operand);
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.operand_value <= operand;
      do @(posedge clock);
      while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      predict_stack_request(op, operand);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic test_empty_stack();
      send_request(OP_POP, $urandom);
      send_request(OP_DISPLAY, $urandom);
      send_request(OP_SEARCH, 32'sd0);
   endtask

   task automatic test_extreme_words();
      send_request(OP_PUSH, 32'sh7fff_ffff);
      send_request(OP_PUSH, 32'sh8000_0000);
      send_request(OP_PUSH, 32'shffff_ffff);
      send_request(OP_PUSH, 32'sh8000_0000);
      send_request(OP_DISPLAY, $urandom);
      send_request(OP_SEARCH, 32'sh8000_0000);
      send_request(OP_SEARCH, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 32'sd0);
   endtask

   task automatic test_full_stack();
      while (entries_held < StackDepth) begin
         send_request(OP_PUSH, 32'sh5555_5555 ^ entries_held);
      end
      send_request(OP_PUSH, 32'sh1234_5678);
      send_request(OP_DISPLAY, $urandom);
      send_request(OP_SEARCH, 32'sh7fff_ffff);
      send_request(OP_POP, $urandom);
   endtask

   // The receiver stalls for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      gaps_on      = 1'b0;
      hold_off_len = 200;
      send_request(OP_DISPLAY, $urandom);
      repeat (11) send_request(weighted_op(), pick_key());
   endtask

   task automatic test_random_sequences();
      int sent;
      int count;
      sent = 0;
      while (sent < 340) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: begin
               count = $urandom_range(1, StackDepth + 2 - entries_held);
               repeat (count) send_request(OP_PUSH, random_word());
            end
            1: begin
               count = entries_held + $urandom_range(0, 1);
               repeat (count) send_request(OP_POP, $urandom);
            end
            2: begin
               count = 20;
               repeat (count) send_request(weighted_op(), pick_key());
            end
            default: begin
               count = 8;
               repeat (count) begin
                  send_request($urandom_range(0, 2) == 0 ? OP_DISPLAY : OP_SEARCH, pick_key());
               end
            end
         endcase
         sent += count;
      end
   endtask

   task automatic test_streaming();
      gaps_on = 1'b0;
      repeat (90) send_request(weighted_op(), pick_key());
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.opcode        <= OP_PUSH;
      req_chan.operand_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_extreme_words();
      test_full_stack();
      test_output_backpressure();
      test_random_sequences();
      test_streaming();
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_chan.ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      stack_word_type w;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected word, value", '0, rsp_chan.result_value);
            end else begin
               w = pending_words.pop_front();
               if (rsp_chan.status !== w.status) begin
                  report_mismatch("status", w.status, rsp_chan.status);
               end
               if (rsp_chan.result_value !== w.value) begin
                  report_mismatch("result_value", w.value, rsp_chan.result_value);
               end
               if (rsp_chan.position_from_top !== w.position) begin
                  report_mismatch("position_from_top", w.position,
                                  rsp_chan.position_from_top);
               end
               if (rsp_chan.last_of_run !== w.last) begin
                  report_mismatch("last_of_run", w.last, rsp_chan.last_of_run);
               end
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
